@@ hw/rtl/ktab_pkg.sv @@
// Shared constants and command and status codes for the keyed table engine.
package ktab_pkg;

   localparam int CAPACITY_DEFAULT    = 32;
   localparam int KEY_WIDTH_DEFAULT   = 32;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int REQ_DATA_WIDTH = 72;
   localparam int RSP_DATA_WIDTH = 48;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_ERASE  = 3'd2;
   localparam logic [2:0] CMD_LOOKUP = 3'd3;
   localparam logic [2:0] CMD_COUNT  = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

endpackage

@@ hw/rtl/keyed_table_engine.sv @@
// Top level of the keyed table engine: sequencer, entry RAM and result register.
//
// The engine keeps up to CAPACITY key and value pairs packed in arrival order in
// one RAM and runs each transaction with a sequencer that reads one entry per
// cycle through the RAM's single read port. Clear and unused command codes go
// straight to the result; insert, lookup and count scan the filled entries;
// erase scans up to the matching slot and then moves each later entry down one
// place, one entry per cycle. The input is not ready while a transaction is in
// progress, and a finished result waits in the output register so that the
// next transaction can be accepted before the result is taken. No clearing pass
// is needed after reset.
module keyed_table_engine #(
   parameter int CAPACITY    = ktab_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH   = ktab_pkg::KEY_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = ktab_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cmd[2:0], key[34:3], value[66:35], zero padding[71:67]
   input  logic [ktab_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[1:0], found[2], read_value[34:3], match_count[40:35], fill[46:41],
   // zero padding[47]
   output logic [ktab_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   import ktab_pkg::*;

   localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
   localparam int VW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]    cmd_ff, cmd_in;
   logic [KW-1:0] key_ff, key_in;
   logic [VW-1:0] value_ff, value_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic [1:0]    status_ff, status_in;
   logic          found_ff, found_in;
   logic [VW-1:0] rval_ff, rval_in;
   logic [FW-1:0] mcount_ff, mcount_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [KW+VW-1:0] wr_data;
   logic [AW-1:0]    rd_addr;
   logic [KW+VW-1:0] rd_data;
   logic [KW-1:0]    rd_key;
   logic [VW-1:0]    rd_val;

   logic          req_fire;
   logic          is_count;
   logic          hit;
   logic [FW+5:0] fill_ext;
   logic [FW+5:0] mcount_ext;
   logic [VW+31:0] rval_ext;

   ktab_ram #(
      .WIDTH(KW + VW),
      .DEPTH(CAPACITY)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rd_key     = rd_data[KW-1:0];
   assign rd_val     = rd_data[KW +: VW];
   assign is_count   = (cmd_ff == CMD_COUNT);
   assign hit        = pend_ff && (is_count ? (rd_val == value_ff) : (rd_key == key_ff));

   assign fill_ext   = {6'b0, fill_ff};
   assign mcount_ext = {6'b0, mcount_ff};
   assign rval_ext   = {32'b0, rval_ff};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      fill_in      = fill_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pidx_in      = issue_ff[AW-1:0];
      status_in    = status_ff;
      found_in     = found_ff;
      rval_in      = rval_ff;
      mcount_in    = mcount_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[AW-1:0];
      wr_data      = {value_ff, key_ff};
      rd_addr      = issue_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_tdata[2:0];
               key_in    = req_tdata[3 +: KW];
               value_in  = req_tdata[35 +: VW];
               issue_in  = '0;
               status_in = STATUS_OK;
               found_in  = 1'b0;
               rval_in   = '0;
               mcount_in = '0;
               if (req_tdata[2:0] == CMD_CLEAR) begin
                  fill_in  = '0;
                  state_in = ST_DONE;
               end else if (req_tdata[2:0] == CMD_INSERT || req_tdata[2:0] == CMD_ERASE ||
                            req_tdata[2:0] == CMD_LOOKUP || req_tdata[2:0] == CMD_COUNT) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (hit && !is_count) begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     status_in = STATUS_DUPLICATE;
                     state_in  = ST_DONE;
                  end
                  CMD_ERASE: begin
                     found_in = 1'b1;
                     issue_in = FW'(pidx_ff) + FW'(1);
                     state_in = ST_SHIFT;
                  end
                  default: begin
                     found_in = 1'b1;
                     rval_in  = rd_val;
                     state_in = ST_DONE;
                  end
               endcase
            end else begin
               if (hit) begin
                  mcount_in = mcount_ff + FW'(1);
               end
               if (issue_ff < fill_ff) begin
                  pend_in  = 1'b1;
                  issue_in = issue_ff + FW'(1);
               end else if (!pend_ff) begin
                  state_in = ST_DONE;
                  case (cmd_ff)
                     CMD_INSERT: begin
                        if (fill_ff == FW'(CAPACITY)) begin
                           status_in = STATUS_FULL;
                        end else begin
                           wr_en   = 1'b1;
                           fill_in = fill_ff + FW'(1);
                        end
                     end
                     CMD_ERASE, CMD_LOOKUP: begin
                        status_in = STATUS_NOT_FOUND;
                     end
                     default: begin
                        status_in = status_ff;
                     end
                  endcase
               end
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff - AW'(1);
               wr_data = rd_data;
            end
            if (issue_ff < fill_ff) begin
               pend_in  = 1'b1;
               issue_in = issue_ff + FW'(1);
            end else if (!pend_ff) begin
               fill_in  = fill_ff - FW'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, fill_ext[5:0], mcount_ext[5:0], rval_ext[31:0],
                               found_ff, status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      issue_ff    <= issue_in;
      pidx_ff     <= pidx_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rval_ff     <= rval_in;
      mcount_ff   <= mcount_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/ktab_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module ktab_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
